// ===== sv/ptw_pkg.sv =====
// Package for the four-level page table walker: word types, result codes,
// level codes and physical address masks. No dependencies.
`default_nettype none
package ptw_pkg;

  localparam int PHYS_ADDR_BITS = 52;   // supported range 36..52
  localparam int OUT_ADDR_W     = 52;
  localparam int LIN_W          = 48;
  localparam int DATA_W         = 64;

  localparam logic [OUT_ADDR_W-1:0] PHYS_MASK =
    (OUT_ADDR_W'(1) << PHYS_ADDR_BITS) - OUT_ADDR_W'(1);
  localparam logic [OUT_ADDR_W-1:0] BASE_4K_MASK = PHYS_MASK & ~OUT_ADDR_W'(32'hFFF);
  localparam logic [OUT_ADDR_W-1:0] BASE_2M_MASK = PHYS_MASK & ~OUT_ADDR_W'(32'h1F_FFFF);
  localparam logic [OUT_ADDR_W-1:0] BASE_1G_MASK = PHYS_MASK & ~OUT_ADDR_W'(32'h3FFF_FFFF);

  localparam int BIT_PRESENT = 0;
  localparam int BIT_PAGE    = 7;

  // input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_FAULT  = 2'd2;
  localparam logic [1:0] KIND_IGNORE = 2'd3;

  // page sizes
  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  // table levels
  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] root_table;
    logic [LIN_W-1:0]  linear_address;
    logic [DATA_W-1:0] read_data;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [OUT_ADDR_W-1:0] address;
    logic [1:0]            page_size;
    logic [OUT_ADDR_W-1:0] entry_address;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/ptw_in_reg.sv =====
// Input register stage of the page table walker.
// Depends on ptw_pkg for the input word type.
`default_nettype none
module ptw_in_reg
  import ptw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     valid_i,
  output logic          ready_o,
  input  wire in_word_t word_i,
  input  wire logic     adv_i,
  output logic          vld_o,
  output in_word_t      word_o
);

  logic     vld_r;
  in_word_t word_r;

  assign ready_o = !vld_r || adv_i;
  assign vld_o   = vld_r;
  assign word_o  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ready_o) begin
      vld_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      word_r <= word_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptw_step.sv =====
// Walk state and per-word decision logic: start, entry check, next request.
// Depends on ptw_pkg for codes, masks and word types.
`default_nettype none
module ptw_step
  import ptw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     adv_i,
  input  wire in_word_t word_i,
  output res_t          res_o
);

  logic [1:0]            level_r, level_nxt;
  logic                  busy_r, busy_nxt;
  logic [LIN_W-1:0]      lin_r, lin_nxt;
  logic [OUT_ADDR_W-1:0] pend_r, pend_nxt;

  logic [OUT_ADDR_W-1:0] data_addr;
  logic [OUT_ADDR_W-1:0] base_addr;
  logic [LIN_W-1:0]      idx_lin;
  logic [1:0]            req_level;
  logic [8:0]            idx;
  logic                  do_req;
  logic [OUT_ADDR_W-1:0] req_addr;
  res_t                  res;

  assign data_addr = word_i.read_data[OUT_ADDR_W-1:0];

  always_comb begin
    idx = 9'd0;
    unique case (req_level)
      LVL_PML4: idx = idx_lin[47:39];
      LVL_PDPT: idx = idx_lin[38:30];
      LVL_PD:   idx = idx_lin[29:21];
      LVL_PT:   idx = idx_lin[20:12];
      default:  idx = 9'd0;
    endcase
  end

  // base low 12 bits are masked off, so the index simply fills them
  assign req_addr = (base_addr & BASE_4K_MASK) | OUT_ADDR_W'({idx, 3'b000});

  always_comb begin
    level_nxt = level_r;
    busy_nxt  = busy_r;
    lin_nxt   = lin_r;
    pend_nxt  = pend_r;
    base_addr = data_addr;
    idx_lin   = lin_r;
    req_level = LVL_PML4;
    do_req    = 1'b0;
    res       = '0;

    if (word_i.op == OP_START) begin
      lin_nxt   = word_i.linear_address;
      busy_nxt  = 1'b1;
      base_addr = word_i.root_table[OUT_ADDR_W-1:0];
      idx_lin   = word_i.linear_address;
      req_level = LVL_PML4;
      do_req    = 1'b1;
    end else if (!busy_r) begin
      res.kind = KIND_IGNORE;
    end else if (!word_i.read_data[BIT_PRESENT]) begin
      busy_nxt          = 1'b0;
      res.kind          = KIND_FAULT;
      res.entry_address = pend_r;
    end else begin
      res.entry_address = pend_r;
      unique case (level_r)
        LVL_PML4: begin
          req_level = LVL_PDPT;
          do_req    = 1'b1;
        end
        LVL_PDPT: begin
          if (word_i.read_data[BIT_PAGE]) begin
            busy_nxt      = 1'b0;
            res.kind      = KIND_DONE;
            res.page_size = SIZE_1G;
            res.address   = (data_addr & BASE_1G_MASK) | OUT_ADDR_W'(lin_r[29:0]);
          end else begin
            req_level = LVL_PD;
            do_req    = 1'b1;
          end
        end
        LVL_PD: begin
          if (word_i.read_data[BIT_PAGE]) begin
            busy_nxt      = 1'b0;
            res.kind      = KIND_DONE;
            res.page_size = SIZE_2M;
            res.address   = (data_addr & BASE_2M_MASK) | OUT_ADDR_W'(lin_r[20:0]);
          end else begin
            req_level = LVL_PT;
            do_req    = 1'b1;
          end
        end
        default: begin
          busy_nxt      = 1'b0;
          res.kind      = KIND_DONE;
          res.page_size = SIZE_4K;
          res.address   = (data_addr & BASE_4K_MASK) | OUT_ADDR_W'(lin_r[11:0]);
        end
      endcase
    end

    if (do_req) begin
      level_nxt         = req_level;
      pend_nxt          = req_addr;
      res.kind          = KIND_REQ;
      res.address       = req_addr;
      res.page_size     = SIZE_4K;
      res.entry_address = req_addr;
    end
  end

  assign res_o = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= LVL_PML4;
      busy_r  <= 1'b0;
      lin_r   <= '0;
      pend_r  <= '0;
    end else if (adv_i) begin
      level_r <= level_nxt;
      busy_r  <= busy_nxt;
      lin_r   <= lin_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ptw_out_reg.sv =====
// Result register stage of the page table walker.
// Depends on ptw_pkg for the result word type.
`default_nettype none
module ptw_out_reg
  import ptw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load_i,
  input  wire res_t res_i,
  output logic      free_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output res_t      res_o
);

  logic vld_r;
  res_t res_r;

  assign free_o  = !vld_r || ready_i;
  assign valid_o = vld_r;
  assign res_o   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (free_o) begin
      vld_r <= load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

endmodule
`default_nettype wire

// ===== sv/four_level_page_table_walker_unit.sv =====
// Four-level page table walker, top level.
// A word passes through the input register, then the result register.
// Throughput: one word per cycle unless the output stalls; input accepted while
// a result waits if the input register drains into a free result register.
// Reset (rst_n low, synchronous): walk idle, level and saved addresses zero.
// Depends on ptw_pkg, ptw_in_reg, ptw_step, ptw_out_reg.
`default_nettype none
module four_level_page_table_walker_unit
  import ptw_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [DATA_W-1:0]     in_root_table,
  input  wire logic [LIN_W-1:0]      in_linear_address,
  input  wire logic [DATA_W-1:0]     in_read_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_kind,
  output logic [OUT_ADDR_W-1:0]      out_address,
  output logic [1:0]                 out_page_size,
  output logic [OUT_ADDR_W-1:0]      out_entry_address
);

  in_word_t in_word, stage_word;
  logic     stage_vld, out_free, adv;
  res_t     step_res, out_res;

  assign in_word.op             = in_op;
  assign in_word.root_table     = in_root_table;
  assign in_word.linear_address = in_linear_address;
  assign in_word.read_data      = in_read_data;

  // advance a word when the result register can take it
  assign adv = stage_vld && out_free;

  ptw_in_reg u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_valid),
    .ready_o (in_ready),
    .word_i  (in_word),
    .adv_i   (adv),
    .vld_o   (stage_vld),
    .word_o  (stage_word)
  );

  ptw_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv_i  (adv),
    .word_i (stage_word),
    .res_o  (step_res)
  );

  ptw_out_reg u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load_i  (adv),
    .res_i   (step_res),
    .free_o  (out_free),
    .valid_o (out_valid),
    .ready_i (out_ready),
    .res_o   (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_address       = out_res.address;
  assign out_page_size     = out_res.page_size;
  assign out_entry_address = out_res.entry_address;

endmodule
`default_nettype wire

// ===== sv/ptw_checker.sv =====
// Port-level checks for the page table walker, bound to the top level.
// Depends on ptw_pkg for result codes.
`default_nettype none
module ptw_checker
  import ptw_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [1:0]            out_kind,
  input wire logic [OUT_ADDR_W-1:0] out_address,
  input wire logic [1:0]            out_page_size,
  input wire logic [OUT_ADDR_W-1:0] out_entry_address
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_address))
    else $error("result word dropped or changed while stalled");

  a_ignore_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_IGNORE |->
      out_address == '0 && out_page_size == SIZE_4K && out_entry_address == '0)
    else $error("ignored response carries nonzero fields");

  a_req_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_REQ |->
      out_address == out_entry_address && out_address[2:0] == 3'b000)
    else $error("request address misaligned or not echoed");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FAULT |-> out_address == '0 && out_page_size == SIZE_4K)
    else $error("fault carries an address or size");

  a_done_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |->
      out_page_size == SIZE_4K || out_page_size == SIZE_2M || out_page_size == SIZE_1G)
    else $error("translation with invalid page size");

endmodule

bind four_level_page_table_walker_unit ptw_checker u_ptw_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_kind          (out_kind),
  .out_address       (out_address),
  .out_page_size     (out_page_size),
  .out_entry_address (out_entry_address)
);
`default_nettype wire

// ===== tb/four_level_page_table_walker_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the four-level page table walker: drives walk starts and table
// entries, predicts every result word in a scoreboard and checks each field.
// Depends on ptw_pkg and four_level_page_table_walker_unit.
module four_level_page_table_walker_unit_tb;
  import ptw_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_WORDS  = 106;

  class walk_scoreboard;
    logic [1:0]            level;
    bit                    busy;
    logic [LIN_W-1:0]      lin_saved;
    logic [OUT_ADDR_W-1:0] pend_addr;
    res_t                  expected_results[$];
    int                    error_count;

    function new();
      level = LVL_PML4;
      busy = 1'b0;
      lin_saved = '0;
      pend_addr = '0;
      error_count = 0;
    endfunction

    // Base comes from the root or the previous entry; index from the saved address.
    function res_t request_entry(logic [OUT_ADDR_W-1:0] base, logic [1:0] lvl);
      res_t r;
      logic [8:0] idx;
      r = '0;
      idx = 9'(lin_saved >> (39 - 9 * int'(lvl)));
      level = lvl;
      pend_addr = (base & BASE_4K_MASK) + OUT_ADDR_W'({idx, 3'b000});
      r.kind = KIND_REQ;
      r.address = pend_addr;
      r.entry_address = pend_addr;
      return r;
    endfunction

    function res_t translate_word(in_word_t w);
      res_t r;
      logic [OUT_ADDR_W-1:0] entry_data;
      r = '0;
      entry_data = w.read_data[OUT_ADDR_W-1:0];
      if (w.op == OP_START) begin
        lin_saved = w.linear_address;
        busy = 1'b1;
        return request_entry(w.root_table[OUT_ADDR_W-1:0], LVL_PML4);
      end
      if (!busy) begin
        r.kind = KIND_IGNORE;
        return r;
      end
      r.entry_address = pend_addr;
      if (!w.read_data[BIT_PRESENT]) begin
        busy = 1'b0;
        r.kind = KIND_FAULT;
        return r;
      end
      r.kind = KIND_DONE;
      case (level)
        LVL_PML4: begin
          return request_entry(entry_data, LVL_PDPT);
        end
        LVL_PDPT: begin
          if (!w.read_data[BIT_PAGE]) return request_entry(entry_data, LVL_PD);
          r.address = (entry_data & BASE_1G_MASK) | OUT_ADDR_W'(lin_saved[29:0]);
          r.page_size = SIZE_1G;
        end
        LVL_PD: begin
          if (!w.read_data[BIT_PAGE]) return request_entry(entry_data, LVL_PT);
          r.address = (entry_data & BASE_2M_MASK) | OUT_ADDR_W'(lin_saved[20:0]);
          r.page_size = SIZE_2M;
        end
        default: begin
          r.address = (entry_data & BASE_4K_MASK) | OUT_ADDR_W'(lin_saved[11:0]);
          r.page_size = SIZE_4K;
        end
      endcase
      busy = 1'b0;
      return r;
    endfunction

    function void note_word(in_word_t w);
      expected_results.push_back(translate_word(w));
    endfunction

    function void compare_field(string name, logic [OUT_ADDR_W-1:0] want,
                                logic [OUT_ADDR_W-1:0] seen);
      if (want !== seen) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
        error_count++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: kind %0d address 0x%0h",
               got.kind, got.address);
        error_count++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("kind", OUT_ADDR_W'(want.kind), OUT_ADDR_W'(got.kind));
      compare_field("address", want.address, got.address);
      compare_field("page_size", OUT_ADDR_W'(want.page_size), OUT_ADDR_W'(got.page_size));
      compare_field("entry_address", want.entry_address, got.entry_address);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_op;
  logic [DATA_W-1:0]     in_root_table;
  logic [LIN_W-1:0]      in_linear_address;
  logic [DATA_W-1:0]     in_read_data;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_kind;
  logic [OUT_ADDR_W-1:0] out_address;
  logic [1:0]            out_page_size;
  logic [OUT_ADDR_W-1:0] out_entry_address;

  walk_scoreboard sb = new();
  int  words_sent = 0;
  int  sender_idle_pct = 0;
  int  receiver_stall_pct = 0;
  bit  hold_off_req = 1'b0;
  int  sender_idle_by_phase[4] = '{0, 86, 0, 24};
  int  receiver_stall_by_phase[4] = '{0, 0, 86, 24};

  four_level_page_table_walker_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_root_table     (in_root_table),
    .in_linear_address (in_linear_address),
    .in_read_data      (in_read_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_address       (out_address),
    .out_page_size     (out_page_size),
    .out_entry_address (out_entry_address)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function in_word_t start_word(logic [DATA_W-1:0] root, logic [LIN_W-1:0] lin);
    in_word_t w;
    w = '0;
    w.op = OP_START;
    w.root_table = root;
    w.linear_address = lin;
    w.read_data = rand64();
    return w;
  endfunction

  function in_word_t response_word(logic [DATA_W-1:0] data);
    in_word_t w;
    w.op = OP_DATA;
    w.root_table = rand64();
    w.linear_address = LIN_W'(rand64());
    w.read_data = data;
    return w;
  endfunction

  function logic [DATA_W-1:0] make_entry(bit present, bit page);
    logic [DATA_W-1:0] d;
    d = rand64();
    d[BIT_PRESENT] = present;
    d[BIT_PAGE] = page;
    return d;
  endfunction

  task automatic send_word(in_word_t w);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_op             <= w.op;
    in_root_table     <= w.root_table;
    in_linear_address <= w.linear_address;
    in_read_data      <= w.read_data;
    do @(posedge clk); while (!in_ready);
    sb.note_word(w);
    words_sent++;
  endtask

  // One walk with random content; it may fault, end on a large page or be abandoned.
  task automatic walk_random();
    bit present;
    bit page;
    bit sized_level;
    if ($urandom_range(99) < 8) send_word(response_word(rand64()));
    send_word(start_word(rand64(), LIN_W'(rand64())));
    for (int lvl = 0; lvl < 4; lvl++) begin
      if ($urandom_range(99) < 5) return;
      sized_level = (lvl == 1) || (lvl == 2);
      present = $urandom_range(99) >= 10;
      page = sized_level ? ($urandom_range(99) < 30) : 1'($urandom_range(1));
      send_word(response_word(make_entry(present, page)));
      if (!present || (page && sized_level)) return;
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    res_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.kind = out_kind;
      seen.address = out_address;
      seen.page_size = out_page_size;
      seen.entry_address = out_entry_address;
      sb.check_result(seen);
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    int target;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_START;
    in_root_table = '0;
    in_linear_address = '0;
    in_read_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // responses with no walk running
    send_word(response_word('1));
    send_word(response_word('0));
    // 4 KB walk at the top of every field; upper entry bits must drop
    send_word(start_word('1, '1));
    send_word(response_word('1));
    send_word(response_word(64'hFFFF_FFFF_FFFF_FF7F));
    send_word(response_word(64'hFFFF_FFFF_FFFF_FF7F));
    send_word(response_word('1));
    // 1 GB frame from zero root and address
    send_word(start_word('0, '0));
    send_word(response_word(64'h1));
    send_word(response_word(64'h81));
    // 2 MB frame
    send_word(start_word(rand64(), LIN_W'(rand64())));
    send_word(response_word(make_entry(1'b1, 1'b0)));
    send_word(response_word(make_entry(1'b1, 1'b0)));
    send_word(response_word('1));
    // fault at the PML4 and at the PT level
    send_word(start_word(rand64(), LIN_W'(rand64())));
    send_word(response_word('0));
    send_word(start_word(rand64(), LIN_W'(rand64())));
    send_word(response_word(make_entry(1'b1, 1'b1)));
    send_word(response_word(make_entry(1'b1, 1'b0)));
    send_word(response_word(make_entry(1'b1, 1'b0)));
    send_word(response_word(64'hFFFF_FFFF_FFFF_FFFE));
    // restart while a walk is running
    send_word(start_word(rand64(), LIN_W'(rand64())));
    send_word(response_word(make_entry(1'b1, 1'b0)));
    send_word(start_word(rand64(), LIN_W'(rand64())));
    send_word(response_word(make_entry(1'b0, 1'b1)));
    pause_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      sender_idle_pct = sender_idle_by_phase[phase];
      receiver_stall_pct = receiver_stall_by_phase[phase];
      // back up the result side while words keep coming
      if (phase == 0) hold_off_req = 1'b1;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) walk_random();
      pause_until_drained();
    end

    if (sb.error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
